// File: rtl/core/glm_pkg.sv
// Shared types, constants and elaboration-time helpers for the gamma mapper.
`timescale 1ns / 1ps
package glm_pkg;

   localparam int PixelBits   = 8;
   localparam int WordBits    = 32;
   localparam int WordLanes   = WordBits / PixelBits;
   localparam int TableDepth  = 256;
   localparam int GammaBits   = 16;
   localparam logic [GammaBits-1:0] GammaReset = 16'd4096;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NORM,
      ST_LOG,
      ST_SCALE,
      ST_EXP,
      ST_SHIFT,
      ST_ROUND,
      ST_WRITE
   } glm_state_type;

   typedef struct packed {
      logic                 en;
      logic [7:0]           addr;
      logic [PixelBits-1:0] data;
   } glm_wr_type;

   typedef struct packed {
      logic busy;
   } glm_status_type;

   // Truncating integer square root, elaboration only.
   function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
      logic [63:0] x;
      logic [63:0] r;
      logic [63:0] b;
      x = x_in;
      r = '0;
      b = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (b > x) b = b >> 2;
      end
      for (int i = 0; i < 32; i++) begin
         if (b != 0) begin
            if (x >= r + b) begin
               x = x - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
      end
      return r;
   endfunction

   // 2^(-2^-k) in Q30 for k = 1..16; entry 0 holds 1.0.
   function automatic logic [16:0][30:0] exp_consts();
      logic [16:0][30:0] c;
      logic [63:0]       t;
      c[0] = 31'(64'd1 << 30);
      t = isqrt64(64'd1 << 59);
      c[1] = t[30:0];
      for (int k = 2; k <= 16; k++) begin
         t = isqrt64({33'd0, c[k-1]} << 30);
         c[k] = t[30:0];
      end
      return c;
   endfunction

   // log2 in Q16 by repeated squaring, elaboration only.
   function automatic logic [18:0] log2_q16(input logic [7:0] x);
      logic [2:0]  e;
      logic [63:0] m;
      logic [15:0] frac;
      e    = '0;
      frac = '0;
      for (int i = 0; i < 8; i++) begin
         if (x[i]) e = 3'(i);
      end
      m = 64'(x) << (30 - e);
      for (int k = 0; k < 16; k++) begin
         m = (m * m) >> 30;
         frac = {frac[14:0], 1'b0};
         if (m >= (64'd2 << 30)) begin
            m = m >> 1;
            frac[0] = 1'b1;
         end
      end
      return {e, frac};
   endfunction

   localparam logic [16:0][30:0] ExpC  = exp_consts();
   localparam logic [18:0]       LgMax = log2_q16(8'd255);

endpackage

// File: rtl/core/glm_if.sv
// Stream and register-write channel interfaces of the gamma mapper.
`timescale 1ns / 1ps
interface glm_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] pixel_word;
   logic        beat_last;
   modport source (output valid, output pixel_word, output beat_last, input ready);
   modport sink   (input valid, input pixel_word, input beat_last, output ready);
endinterface

interface glm_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] mapped_word;
   logic        mapped_last;
   modport source (output valid, output mapped_word, output mapped_last, input ready);
   modport sink   (input valid, input mapped_word, input mapped_last, output ready);
endinterface

interface glm_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] gamma_q4_12;
   modport source (output valid, output gamma_q4_12, input ready);
   modport sink   (input valid, input gamma_q4_12, output ready);
endinterface

// File: rtl/core/glm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module glm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/core/glm_builder.sv
// Table builder: one shared multiplier walks log2, scale and exp2 per entry.
`timescale 1ns / 1ps
module glm_builder (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [15:0]            csr_data,
   output glm_pkg::glm_wr_type     wr,
   output glm_pkg::glm_status_type status
);
   import glm_pkg::*;

   glm_state_type state_ff, state_in;
   logic [7:0]  idx_ff,   idx_in;
   logic [15:0] gamma_ff, gamma_in;
   logic [30:0] m_ff,     m_in;
   logic [15:0] frac_ff,  frac_in;
   logic [2:0]  e_ff,     e_in;
   logic [3:0]  round_ff, round_in;
   logic [22:0] mag_ff,   mag_in;
   logic [7:0]  entry_ff, entry_in;

   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic [63:0] prod;
   logic [2:0]  top_bit;
   logic [31:0] sq;
   logic [18:0] lg_diff;
   logic [6:0]  whole;
   logic [39:0] scaled;
   logic [9:0]  y;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_NORM;
         idx_ff   <= '0;
         gamma_ff <= GammaReset;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         gamma_ff <= gamma_in;
      end
      m_ff     <= m_in;
      frac_ff  <= frac_in;
      e_ff     <= e_in;
      round_ff <= round_in;
      mag_ff   <= mag_in;
      entry_ff <= entry_in;
   end

   always_comb begin
      top_bit = '0;
      for (int i = 0; i < 8; i++) begin
         if (idx_ff[i]) top_bit = 3'(i);
      end
   end

   always_comb begin
      unique case (state_ff)
         ST_LOG:   begin mul_a = {1'b0, m_ff};    mul_b = {1'b0, m_ff};      end
         ST_SCALE: begin mul_a = {13'd0, lg_diff}; mul_b = {16'd0, gamma_ff}; end
         ST_EXP:   begin
            mul_a = {1'b0, m_ff};
            mul_b = {1'b0, ExpC[5'(round_ff) + 5'd1]};
         end
         default:  begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign prod    = mul_a * mul_b;
   assign sq      = prod[61:30];
   assign lg_diff = LgMax - {e_ff, frac_ff};
   assign whole   = mag_ff[22:16];
   assign scaled  = 40'(m_ff) * 40'd255 + 40'(33'd1 << 25);
   assign y       = scaled[39:30];

   // Next state.
   always_comb begin
      state_in = state_ff;
      if (csr_we) begin
         state_in = ST_NORM;
      end else begin
         unique case (state_ff)
            ST_IDLE:  state_in = ST_IDLE;
            ST_NORM:  state_in = (idx_ff == 8'd0) ? ST_WRITE : ST_LOG;
            ST_LOG:   state_in = (round_ff == 4'd15) ? ST_SCALE : ST_LOG;
            ST_SCALE: state_in = ST_EXP;
            ST_EXP:   state_in = (round_ff == 4'd15) ? ST_SHIFT : ST_EXP;
            ST_SHIFT: state_in = ST_ROUND;
            ST_ROUND: state_in = ST_WRITE;
            ST_WRITE: state_in = (idx_ff == 8'd255) ? ST_IDLE : ST_NORM;
            default:  state_in = ST_IDLE;
         endcase
      end
   end

   // Datapath and outputs.
   always_comb begin
      idx_in   = idx_ff;
      gamma_in = gamma_ff;
      m_in     = m_ff;
      frac_in  = frac_ff;
      e_in     = e_ff;
      round_in = round_ff;
      mag_in   = mag_ff;
      entry_in = entry_ff;
      wr.en    = 1'b0;
      wr.addr  = idx_ff;
      wr.data  = entry_ff;
      unique case (state_ff)
         ST_NORM: begin
            e_in     = top_bit;
            m_in     = 31'(idx_ff) << (5'd30 - 5'(top_bit));
            frac_in  = '0;
            round_in = '0;
            entry_in = (gamma_ff == 16'd0) ? 8'd255 : 8'd0;
         end
         ST_LOG: begin
            frac_in  = {frac_ff[14:0], sq[31]};
            m_in     = sq[31] ? sq[31:1] : sq[30:0];
            round_in = round_ff + 4'd1;
         end
         ST_SCALE: begin
            mag_in   = prod[34:12];
            m_in     = 31'(32'd1 << 30);
            round_in = '0;
         end
         ST_EXP: begin
            if (mag_ff[4'd15 - round_ff]) m_in = prod[60:30];
            round_in = round_ff + 4'd1;
         end
         ST_SHIFT: m_in = (whole >= 7'd31) ? '0 : (m_ff >> whole);
         ST_ROUND: entry_in = (y > 10'd255) ? 8'd255 : y[7:0];
         ST_WRITE: begin
            wr.en  = 1'b1;
            idx_in = idx_ff + 8'd1;
         end
         default: ;
      endcase
      if (csr_we) begin
         gamma_in = csr_data;
         idx_in   = '0;
         wr.en    = 1'b0;
      end
   end

   assign status.busy = (state_ff != ST_IDLE);
endmodule

// File: rtl/core/glm_merge.sv
// Merge stage: gather lane bytes into the output word register.
`timescale 1ns / 1ps
module glm_merge #(
   parameter int USED_LANES = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [USED_LANES*8-1:0]   in_lanes,
   input  logic                      in_last,
   output logic                      in_ready,
   glm_rsp_if.source                 rsp_if
);
   import glm_pkg::*;

   logic                rsp_valid_ff;
   logic [WordBits-1:0] word_ff, word_in;
   logic                last_ff;

   assign in_ready = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      word_in = '0;
      for (int k = 0; k < USED_LANES; k++) begin
         word_in[k*PixelBits +: PixelBits] = in_lanes[k*PixelBits +: PixelBits];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (in_ready) begin
         rsp_valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         word_ff <= word_in;
         last_ff <= in_last;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.mapped_word = word_ff;
   assign rsp_if.mapped_last = last_ff;
endmodule

// File: rtl/core/gamma_lut_pixel_mapper.sv
// Top level of the gamma-correcting pixel mapper.
`timescale 1ns / 1ps
// Gamma correction of a 32-bit pixel stream, one byte lane per pixel. Every
// word accepted on req_if has each of its first LANES byte lanes (at most four
// fit the word) replaced by entry lane of a 256-entry gamma table; lanes above
// that come out zero and the last flag passes straight through. Throughput is
// one word per clock while rsp_if takes words and no rebuild runs. Words pass
// through the registered table read and the output register that lets req_if
// take a new word while a finished one waits on rsp_if. Each lane owns a copy
// of the table so all lanes read at once. The table is rebuilt after reset and
// after every write of gamma_q4_12 on csr_if (Q4.12, reset 1.0 = identity);
// a rebuild walks the entries in turn on the single shared multiplier, which
// steps through 16 squaring rounds of log2 and 16 steps of exp2 per entry
// (entry zero is written directly). req_if stays not ready while the table
// is rebuilt. Write gamma only while idle.
module gamma_lut_pixel_mapper #(
   parameter int LANES = 4
) (
   input logic        clock,
   input logic        reset,
   glm_req_if.sink    req_if,
   glm_rsp_if.source  rsp_if,
   glm_csr_if.sink    csr_if
);
   import glm_pkg::*;

   localparam int UsedLanes = (LANES < WordLanes) ? LANES : WordLanes;

   glm_wr_type     tbl_wr;
   glm_status_type build_stat;

   logic                      accept;
   logic                      merge_ready;
   logic                      valid_a_ff;
   logic                      last_a_ff;
   logic [UsedLanes*8-1:0]    lane_q;

   // Register writes are always taken; each one restarts the table build.
   assign csr_if.ready = 1'b1;

   glm_builder u_builder (
      .clock  (clock),
      .reset  (reset),
      .csr_we (csr_if.valid && csr_if.ready),
      .csr_data(csr_if.gamma_q4_12),
      .wr     (tbl_wr),
      .status (build_stat)
   );

   // Take a word when the table is settled and the read stage can move on.
   assign req_if.ready = !build_stat.busy && (!valid_a_ff || merge_ready);
   assign accept       = req_if.valid && req_if.ready;

   // One table copy per lane; the builder writes all copies together.
   for (genvar k = 0; k < UsedLanes; k++) begin : g_lane
      glm_ram #(
         .WIDTH (PixelBits),
         .DEPTH (TableDepth)
      ) u_ram (
         .clock   (clock),
         .wr_en   (tbl_wr.en),
         .wr_addr (tbl_wr.addr),
         .wr_data (tbl_wr.data),
         .rd_en   (accept),
         .rd_addr (req_if.pixel_word[k*PixelBits +: PixelBits]),
         .rd_data (lane_q[k*PixelBits +: PixelBits])
      );
   end

   // Read stage control: advance with the RAM output, hold when merge stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else if (accept) begin
         valid_a_ff <= 1'b1;
      end else if (merge_ready) begin
         valid_a_ff <= 1'b0;
      end
      if (accept) last_a_ff <= req_if.beat_last;
   end

   glm_merge #(
      .USED_LANES (UsedLanes)
   ) u_merge (
      .clock    (clock),
      .reset    (reset),
      .in_valid (valid_a_ff),
      .in_lanes (lane_q),
      .in_last  (last_a_ff),
      .in_ready (merge_ready),
      .rsp_if   (rsp_if)
   );
endmodule

// File: rtl/core/glm_checker.sv
// Port-level checks of the gamma mapper, bound to the top level.
`timescale 1ns / 1ps
module glm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_word,
   input logic        rsp_last,
   input logic        csr_valid,
   input logic        csr_ready
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_word) && $stable(rsp_last))
      else $error("rsp payload changed while stalled");

   a_csr_rebuild: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> !req_ready)
      else $error("req taken during table rebuild");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("block not quiet after reset");
endmodule

bind gamma_lut_pixel_mapper glm_checker u_glm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_word  (rsp_if.mapped_word),
   .rsp_last  (rsp_if.mapped_last),
   .csr_valid (csr_if.valid),
   .csr_ready (csr_if.ready)
);
